### rtl/core/lct_pkg.sv
// Shared types and constants for the LFU cache table core.
package lct_pkg;

    localparam int W_DATA  = 32;
    localparam int W_CAP   = 5;
    localparam int W_COUNT = 32;

    localparam logic [W_CAP-1:0]         CAP_RESET = 5'd16;
    localparam logic                     CMD_GET   = 1'b0;
    localparam logic                     CMD_PUT   = 1'b1;
    localparam logic signed [W_DATA-1:0] VAL_MISS  = -32'sd1;
    localparam logic [W_COUNT-1:0]       COUNT_MAX = '1;

    typedef struct packed {
        logic                     cmd;
        logic signed [W_DATA-1:0] key;
        logic signed [W_DATA-1:0] value;
    } t_in;

    typedef struct packed {
        logic                     hit;
        logic signed [W_DATA-1:0] read_value;
        logic                     evicted;
        logic signed [W_DATA-1:0] evicted_key;
    } t_out;

    typedef struct packed {
        logic load_in;
        logic scan_step;
        logic touch;
        logic upd_value;
        logic remove;
        logic insert;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic scan_last;
        logic cmd_put;
        logic hit;
        logic cap_zero;
        logic need_evict;
        logic out_free;
    } t_sts;

endpackage

### rtl/core/lct_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lct_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/lct_ctrl.sv
// Request sequencer: accept, scan, act, insert, respond.
module lct_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  lct_pkg::t_sts i_sts,
    output lct_pkg::t_ctl o_ctl,
    output logic          o_in_stall
);
    import lct_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_LAST = 3'd2;
    localparam logic [2:0] S_ACT  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       put_miss;

    assign put_miss = i_sts.cmd_put && !i_sts.cap_zero && !i_sts.hit;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_ctl.load_in = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_ctl.scan_step = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_state = S_ACT;
            end
            S_ACT: begin
                if (put_miss) begin
                    o_ctl.remove = i_sts.need_evict;
                    n_state      = S_INS;
                end else if (i_sts.out_free) begin
                    o_ctl.touch     = i_sts.hit && (!i_sts.cmd_put || !i_sts.cap_zero);
                    o_ctl.upd_value = i_sts.hit && i_sts.cmd_put && !i_sts.cap_zero;
                    o_ctl.load_out  = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_INS: begin
                if (i_sts.out_free) begin
                    o_ctl.insert   = 1'b1;
                    o_ctl.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

### rtl/core/lct_dpath.sv
// Datapath: entry storage, recency lanes, scan results and output register.
module lct_dpath #(
    parameter int ENTRIES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lct_pkg::t_ctl               i_ctl,
    output lct_pkg::t_sts               o_sts,
    input  lct_pkg::t_in                i_in_data,
    input  logic                        i_cfg_wr_en,
    input  logic [lct_pkg::W_CAP-1:0]   i_cfg_wr_data,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output lct_pkg::t_out               o_out_data
);
    import lct_pkg::*;

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int EW = (OW > W_CAP) ? OW : W_CAP;

    t_in                r_in;
    logic [W_CAP-1:0]   r_cap;
    logic [OW-1:0]      r_occ;
    logic [ENTRIES-1:0] r_valid;
    logic [IW-1:0]      r_rank [ENTRIES];
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_eval_idx;
    logic               r_eval_en;

    logic               r_hit;
    logic [IW-1:0]      r_slot;
    logic [W_DATA-1:0]  r_mval;
    logic [W_COUNT-1:0] r_mcnt;
    logic [IW-1:0]      r_mrank;

    logic               r_vic_ok;
    logic [IW-1:0]      r_vic;
    logic [W_COUNT-1:0] r_vcnt;
    logic [IW-1:0]      r_vrank;
    logic [W_DATA-1:0]  r_vkey;

    logic               r_free_ok;
    logic [IW-1:0]      r_free;

    logic               r_ev;
    logic [W_DATA-1:0]  r_evk;
    logic               r_out_valid;
    t_out               r_out;

    logic [W_DATA-1:0]  key_rd;
    logic [W_DATA-1:0]  val_rd;
    logic [W_COUNT-1:0] cnt_rd;
    logic [IW-1:0]      eval_rank;
    logic               eval_valid;
    logic [IW-1:0]      ins_slot;
    logic [IW-1:0]      wr_addr;
    logic [W_COUNT-1:0] cnt_inc;
    logic [W_COUNT-1:0] cnt_wdata;
    logic [EW-1:0]      cap_ext;
    logic [EW-1:0]      eff_cap;

    assign eval_rank  = r_rank[r_eval_idx];
    assign eval_valid = r_valid[r_eval_idx];
    assign ins_slot   = (r_ev && !(r_free_ok && (r_free < r_vic))) ? r_vic : r_free;
    assign wr_addr    = i_ctl.insert ? ins_slot : r_slot;
    assign cnt_inc    = (r_mcnt == COUNT_MAX) ? r_mcnt : r_mcnt + W_COUNT'(1);
    assign cnt_wdata  = i_ctl.insert ? '0 : cnt_inc;
    assign cap_ext    = EW'(r_cap);
    assign eff_cap    = (cap_ext > EW'(ENTRIES)) ? EW'(ENTRIES) : cap_ext;

    lct_ram #(.WIDTH(W_DATA), .DEPTH(ENTRIES)) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.insert),
        .i_waddr (wr_addr),
        .i_wdata (r_in.key),
        .i_raddr (r_idx),
        .o_rdata (key_rd)
    );

    lct_ram #(.WIDTH(W_DATA), .DEPTH(ENTRIES)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.insert || i_ctl.upd_value),
        .i_waddr (wr_addr),
        .i_wdata (r_in.value),
        .i_raddr (r_idx),
        .o_rdata (val_rd)
    );

    lct_ram #(.WIDTH(W_COUNT), .DEPTH(ENTRIES)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.insert || i_ctl.touch),
        .i_waddr (wr_addr),
        .i_wdata (cnt_wdata),
        .i_raddr (r_idx),
        .o_rdata (cnt_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_occ       <= '0;
            r_valid     <= '0;
            r_eval_en   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            r_eval_en <= i_ctl.scan_step;
            if (i_ctl.remove) begin
                r_valid[r_vic] <= 1'b0;
                r_occ          <= r_occ - OW'(1);
            end
            if (i_ctl.insert) begin
                r_valid[ins_slot] <= 1'b1;
                r_occ             <= r_occ + OW'(1);
            end
            if (i_ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_in) begin
            r_in      <= i_in_data;
            r_idx     <= '0;
            r_hit     <= 1'b0;
            r_vic_ok  <= 1'b0;
            r_free_ok <= 1'b0;
            r_ev      <= 1'b0;
        end
        if (i_ctl.scan_step) begin
            r_idx <= r_idx + IW'(1);
        end
        r_eval_idx <= r_idx;
        if (r_eval_en) begin
            if (eval_valid && (key_rd == r_in.key) && !r_hit) begin
                r_hit   <= 1'b1;
                r_slot  <= r_eval_idx;
                r_mval  <= val_rd;
                r_mcnt  <= cnt_rd;
                r_mrank <= eval_rank;
            end
            if (eval_valid && (!r_vic_ok || (cnt_rd < r_vcnt) ||
                               ((cnt_rd == r_vcnt) && (eval_rank > r_vrank)))) begin
                r_vic_ok <= 1'b1;
                r_vic    <= r_eval_idx;
                r_vcnt   <= cnt_rd;
                r_vrank  <= eval_rank;
                r_vkey   <= key_rd;
            end
            if (!eval_valid && !r_free_ok) begin
                r_free_ok <= 1'b1;
                r_free    <= r_eval_idx;
            end
        end
        if (i_ctl.remove) begin
            r_ev  <= 1'b1;
            r_evk <= r_vkey;
        end
        if (i_ctl.load_out) begin
            r_out.hit         <= r_hit;
            r_out.read_value  <= (r_in.cmd == CMD_PUT) ? '0 :
                                 (r_hit ? $signed(r_mval) : VAL_MISS);
            r_out.evicted     <= r_ev;
            r_out.evicted_key <= r_ev ? $signed(r_evk) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < ENTRIES; j++) begin
            if (i_ctl.touch) begin
                if (IW'(j) == r_slot) begin
                    r_rank[j] <= '0;
                end else if (r_valid[j] && (r_rank[j] < r_mrank)) begin
                    r_rank[j] <= r_rank[j] + IW'(1);
                end
            end
            if (i_ctl.remove) begin
                if (r_valid[j] && (r_rank[j] > r_vrank)) begin
                    r_rank[j] <= r_rank[j] - IW'(1);
                end
            end
            if (i_ctl.insert) begin
                if (IW'(j) == ins_slot) begin
                    r_rank[j] <= '0;
                end else if (r_valid[j]) begin
                    r_rank[j] <= r_rank[j] + IW'(1);
                end
            end
        end
    end

    assign o_sts.scan_last  = (r_idx == IW'(ENTRIES - 1));
    assign o_sts.cmd_put    = (r_in.cmd == CMD_PUT);
    assign o_sts.hit        = r_hit;
    assign o_sts.cap_zero   = (r_cap == '0);
    assign o_sts.need_evict = (EW'(r_occ) >= eff_cap);
    assign o_sts.out_free   = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### rtl/core/lfu_cache_table_core.sv
// Top level of the LFU cache table: sequencer plus datapath.
//
//  channel | ports                                  | word
//  --------+----------------------------------------+-----------------------------
//  in      | i_in_valid, o_in_stall, i_in_data      | cmd, key, value
//  out     | o_out_valid, i_out_stall, o_out_data   | hit, read_value, evicted,
//          |                                        | evicted_key
//  cfg     | i_cfg_wr_en, i_cfg_wr_data             | capacity
//
// A request is accepted, then the key/victim scan walks every slot in order through
// the key, value and count RAM read ports; the update and result load follow, with
// an extra insert step on a put miss. The next word can be taken in the cycle after
// the result loads.
// Synchronous active-low reset clears the valid bits, occupancy and output valid
// flag and sets capacity to 16; no clearing pass is needed.
// A result held by i_out_stall does not block the next accept; the following request
// evicts its victim on a put miss, but its other updates wait for a free output register.
module lfu_cache_table_core #(
    parameter int ENTRIES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  lct_pkg::t_in              i_in_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output lct_pkg::t_out             o_out_data,
    input  logic                      i_cfg_wr_en,
    input  logic [lct_pkg::W_CAP-1:0] i_cfg_wr_data
);
    import lct_pkg::*;

    t_ctl ctl;
    t_sts sts;

    lct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_ctl      (ctl),
        .o_in_stall (o_in_stall)
    );

    lct_dpath #(.ENTRIES(ENTRIES)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_in_data     (i_in_data),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("accepted word did not start a scan");

    a_load_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.load_out |-> sts.out_free)
        else $error("result loaded over an untaken word");

    a_touch_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.touch |-> sts.hit)
        else $error("recency update without a key match");

    a_insert_on_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.insert |-> (sts.cmd_put && !sts.hit && !sts.cap_zero))
        else $error("insert outside a put miss");

endmodule
